// File: src/dht_pkg.sv
// Shared types, constants and request/status codes for the double hash table.
// No dependencies.
package dht_pkg;
  localparam int TableDepth = 128;
  localparam int KeyWidth   = 31;
  localparam int ValueWidth = 32;
  localparam int SlotWidth  = $clog2(TableDepth);
  localparam int CfgWidth   = 8;
  localparam int CfgIdxWidth = 1;

  localparam logic [1:0] ReqInsert = 2'd0;
  localparam logic [1:0] ReqFind   = 2'd1;
  localparam logic [1:0] ReqDelete = 2'd2;
  localparam logic [1:0] ReqNone   = 2'd3;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StMissing = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;

  localparam logic [CfgIdxWidth-1:0] CfgTableSize = 1'd0;
  localparam logic [CfgIdxWidth-1:0] CfgStepMod   = 1'd1;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [KeyWidth-1:0]   key;
    logic [ValueWidth-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [ValueWidth-1:0] found_value;
  } rsp_t;

  typedef struct packed {
    logic                 start;
    logic [KeyWidth-1:0]  dividend;
    logic [CfgWidth-1:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic                 done;
    logic [CfgWidth-1:0]  rem;
  } mod_rsp_t;
endpackage

// File: src/dht_if.sv
// Valid/ready channel carrying one payload word.
// Depends on nothing; payload type is a type parameter.
interface dht_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: src/dht_mod.sv
// Bit-serial remainder unit: key mod divisor, one dividend bit per cycle.
// Depends on dht_pkg.
module dht_mod
  import dht_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mod_req_t req_i,
  output mod_rsp_t rsp_o
);
  localparam int CntWidth = $clog2(KeyWidth + 1);
  logic [KeyWidth-1:0] dvd_q, dvd_d;
  logic [CfgWidth:0]   rem_q, rem_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic [CfgWidth:0]   shifted, rem_next;

  always_comb begin
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    shifted  = {rem_q[CfgWidth-1:0], dvd_q[KeyWidth-1]};
    rem_next = (shifted >= {1'b0, req_i.divisor}) ?
               shifted - {1'b0, req_i.divisor} : shifted;
    if (req_i.start) begin
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      cnt_d  = CntWidth'(KeyWidth);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[KeyWidth-2:0], 1'b0};
      rem_d = rem_next;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntWidth'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = busy_q && cnt_q == CntWidth'(1);
  assign rsp_o.rem  = rem_next[CfgWidth-1:0];
endmodule

// File: src/double_hash_table_core.sv
// Double-hashing open-addressing hash table, top level.
// Depends on dht_pkg, dht_if and dht_mod.
//
// Requests arrive on req (insert, find, delete with key and value); each
// gives exactly one response on rsp (status and found value). Registers
// table_size (index 0) and step_mod (index 1) are written through cfg_we_i.
// A request runs through a sequencer: three bit-serial remainders
// (key mod step_mod, key mod table_size, step mod table_size), then a probe
// sequence stepping by step for insert and find, or a linear sweep of slots
// for delete, reading the key and value memories through one registered read
// port (states SRead then SEval per probe). At worst n_eff slots (table_size
// clamped to 1..128) are probed; insert stops at the first free slot and find
// at the first match. One request is in work at a time; req is not ready
// until the response has been taken. If the receiver stalls, the response
// holds in the output register and no request is taken.
// Reset clears all slot valid bits and sets both registers to 100; key and
// value memories are not cleared.
module double_hash_table_core
  import dht_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  dht_if.sink                    req,
  dht_if.source                  rsp,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_data_i
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SModM = 3'd1;
  localparam logic [2:0] SModN = 3'd2;
  localparam logic [2:0] SRead = 3'd3;
  localparam logic [2:0] SEval = 3'd4;
  localparam logic [2:0] SResp = 3'd5;
  localparam logic [2:0] SModS = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [CfgWidth-1:0]   tsize_q, smod_q;
  logic [TableDepth-1:0] valid_q;
  logic [KeyWidth-1:0]   mem_key [TableDepth];
  logic [ValueWidth-1:0] mem_val [TableDepth];
  logic [KeyWidth-1:0]   rd_key_q;
  logic [ValueWidth-1:0] rd_val_q;
  req_t                  req_q;
  rsp_t                  rsp_q;
  logic [CfgWidth:0]     n_eff, m_eff;
  logic [CfgWidth:0]     step_q, slot_q, j_q;
  logic                  hit_q;
  mod_req_t              mreq;
  mod_rsp_t              mrsp;
  logic [SlotWidth-1:0]  sidx;
  logic [CfgWidth+1:0]   stepsum;
  logic [CfgWidth+1:0]   nextslot;
  logic                  last_probe, match;

  assign n_eff = (tsize_q == '0) ? 9'd1 :
                 ({1'b0, tsize_q} > 9'(TableDepth)) ? 9'(TableDepth) : {1'b0, tsize_q};
  assign m_eff = (smod_q == '0) ? 9'd1 : {1'b0, smod_q};

  assign mreq.dividend = (state_q == SIdle) ? req.payload.key :
                         (state_q == SModN) ? {{(KeyWidth-CfgWidth-1){1'b0}}, step_q} :
                         req_q.key;
  assign mreq.divisor  = (state_q == SModM) ? m_eff[CfgWidth-1:0] : n_eff[CfgWidth-1:0];
  assign mreq.start    = (state_q == SIdle && req.valid) ||
                         (state_q == SModM && mrsp.done) ||
                         (state_q == SModN && mrsp.done);

  dht_mod u_mod (.clk_i, .rst_ni, .req_i(mreq), .rsp_o(mrsp));

  assign sidx       = slot_q[SlotWidth-1:0];
  assign stepsum    = {1'b0, slot_q} + {1'b0, step_q};
  assign nextslot   = (stepsum >= {1'b0, n_eff}) ? stepsum - {1'b0, n_eff} : stepsum;
  assign last_probe = (j_q + 1'b1) >= n_eff;
  assign match      = valid_q[sidx] && rd_key_q == req_q.key;

  assign req.ready   = state_q == SIdle;
  assign rsp.valid   = state_q == SResp;
  assign rsp.payload = rsp_q;

  always_ff @(posedge clk_i) begin
    rd_key_q <= mem_key[sidx];
    rd_val_q <= mem_val[sidx];
    if (state_q == SEval && req_q.req_type == ReqInsert && !valid_q[sidx]) begin
      mem_key[sidx] <= req_q.key;
      mem_val[sidx] <= req_q.value;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: if (req.valid) state_d = SModM;
      SModM: if (mrsp.done) state_d = SModN;
      SModN: if (mrsp.done) state_d = SModS;
      SModS: if (mrsp.done) state_d = (req_q.req_type == ReqNone) ? SResp : SRead;
      SRead: state_d = SEval;
      SEval: begin
        if (req_q.req_type == ReqInsert && !valid_q[sidx]) state_d = SResp;
        else if (req_q.req_type == ReqFind && match) state_d = SResp;
        else if (last_probe) state_d = SResp;
        else state_d = SRead;
      end
      SResp: if (rsp.ready) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      tsize_q <= 8'd100;
      smod_q  <= 8'd100;
      valid_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && cfg_idx_i == CfgTableSize) tsize_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == CfgStepMod) smod_q <= cfg_data_i;
      if (state_q == SIdle) hit_q <= 1'b0;
      if (state_q == SEval) begin
        if (req_q.req_type == ReqInsert && !valid_q[sidx]) valid_q[sidx] <= 1'b1;
        if (req_q.req_type == ReqDelete && match) begin
          valid_q[sidx] <= 1'b0;
          hit_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && req.valid) req_q <= req.payload;
    if (state_q == SModM && mrsp.done) step_q <= m_eff - {1'b0, mrsp.rem};
    if (state_q == SModN && mrsp.done) begin
      j_q <= '0;
      slot_q <= (req_q.req_type == ReqDelete) ? '0 : {1'b0, mrsp.rem};
      rsp_q <= '{status: StMissing, found_value: '0};
    end
    if (state_q == SModS && mrsp.done) step_q <= {1'b0, mrsp.rem};
    if (state_q == SEval) begin
      j_q <= j_q + 1'b1;
      slot_q <= (req_q.req_type == ReqDelete) ? slot_q + 1'b1 : nextslot[CfgWidth:0];
      case (req_q.req_type)
        ReqInsert: begin
          if (!valid_q[sidx]) rsp_q.status <= StOk;
          else if (last_probe) rsp_q.status <= StFull;
        end
        ReqFind: if (match) rsp_q <= '{status: StOk, found_value: rd_val_q};
        ReqDelete: if (last_probe) rsp_q.status <= (hit_q || match) ? StOk : StMissing;
        default: rsp_q <= rsp_q;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.ready |-> !rsp.valid) else $error("ready while response pending");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp_q)) else $error("response dropped");
  a_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp_q.status != StOk |-> rsp_q.found_value == '0)
    else $error("nonzero value on miss");
`endif
endmodule
